// ===== design/multi_buffer_sample_ring_core_defines.svh =====
// ----------------------------------------------------------------------------
// multi_buffer_sample_ring_core_defines
// assertion macros used by the sample ring core
// ----------------------------------------------------------------------------
`ifndef MULTI_BUFFER_SAMPLE_RING_CORE_DEFINES_SVH
`define MULTI_BUFFER_SAMPLE_RING_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define MBSR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbsr assertion failed");

// condition holds in the next cycle
`define MBSR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbsr assertion failed");

`else

`define MBSR_ASSERT_NOW(name, clk, rst, ante, cons)
`define MBSR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/mbsr_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsr_pkg
// shared types and constants of the sample ring
// ----------------------------------------------------------------------------
package mbsr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int READY_W  = 3;

   // operation codes on req_func
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear_wr;
      logic add;
      logic fetch_start;
      logic fetch_issue;
   } mbsr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic credit_ok;
      logic burst_end;
   } mbsr_sts_type;

   // one result entry of the output queue
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic [READY_W-1:0]         ready;
   } mbsr_entry_type;

endpackage

// ===== design/mbsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbsr_ctrl
// controller state machine: clearing pass, idle accept, fetch burst issue
// ----------------------------------------------------------------------------
module mbsr_ctrl import mbsr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_func,
   input  mbsr_sts_type sts,
   output mbsr_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && sts.credit_ok);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd             = '0;
      cmd.clear_wr    = (state_ff == ST_CLEAR);
      cmd.add         = accept && (req_func == FUNC_ADD);
      cmd.fetch_start = accept && (req_func == FUNC_FETCH);
      cmd.fetch_issue = (state_ff == ST_FETCH) && sts.credit_ok;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.fetch_start) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (cmd.fetch_issue && sts.burst_end) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/mbsr_datapath.sv =====
// ----------------------------------------------------------------------------
// mbsr_datapath
// sample memory, fill and ready counters, read pipe and output queue
// ----------------------------------------------------------------------------
module mbsr_datapath import mbsr_pkg::*; #(
   parameter int NUM_BUFFERS        = 4,
   parameter int SAMPLES_PER_BUFFER = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbsr_cmd_type               cmd,
   output mbsr_sts_type               sts,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_last,
   output logic [READY_W-1:0]         rsp_ready_count
);

   localparam int DEPTH  = NUM_BUFFERS * SAMPLES_PER_BUFFER;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BUF_W  = $clog2(NUM_BUFFERS);
   localparam int POS_W  = $clog2(SAMPLES_PER_BUFFER);
   localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);
   localparam int SEL_W  = CNT_W + 1;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [BUF_W-1:0]  fill_buf_ff, fill_buf_in;
   logic [POS_W-1:0]  fill_pos_ff, fill_pos_in;
   logic [CNT_W-1:0]  ready_ff, ready_in;
   logic [POS_W-1:0]  burst_pos_ff, burst_pos_in;
   logic [ADDR_W-1:0] base_ff, base_in;

   logic               pipe_vld_ff, pipe_vld_in;
   logic               pipe_status_ff;
   logic               pipe_last_ff;
   logic [READY_W-1:0] pipe_rdy_ff, pipe_rdy_in;

   mbsr_entry_type q_ff [2];
   mbsr_entry_type push_entry;
   logic           q_wr_ptr_ff, q_wr_ptr_in;
   logic           q_rd_ptr_ff, q_rd_ptr_in;
   logic [1:0]     q_cnt_ff, q_cnt_in;
   logic           push, pop;
   logic [2:0]     room_sum;

   logic                 fill_wrap, buf_wrap;
   logic [ADDR_W-1:0]    fill_addr, wr_addr, rd_addr;
   logic [SAMPLE_W-1:0]  wr_data;
   logic                 mem_wr;
   logic [SEL_W-1:0]     fill_ext, rdy_ext, sel_wide;
   logic [BUF_W-1:0]     sel_buf;
   logic [CNT_W+READY_W-1:0] rdy_pad;

   // fill position and ready count
   assign fill_wrap = (fill_pos_ff == POS_W'(SAMPLES_PER_BUFFER - 1));
   assign buf_wrap  = (fill_buf_ff == BUF_W'(NUM_BUFFERS - 1));

   always_comb begin
      fill_pos_in = fill_pos_ff;
      fill_buf_in = fill_buf_ff;
      ready_in    = ready_ff;
      if (cmd.add) begin
         if (fill_wrap) begin
            fill_pos_in = '0;
            fill_buf_in = buf_wrap ? '0 : fill_buf_ff + 1'b1;
            if (ready_ff != CNT_W'(NUM_BUFFERS)) ready_in = ready_ff + 1'b1;
         end else begin
            fill_pos_in = fill_pos_ff + 1'b1;
         end
      end
      if (cmd.fetch_start && (ready_ff != '0)) ready_in = ready_ff - 1'b1;
   end

   // oldest ready buffer, modulo the buffer count
   always_comb begin
      fill_ext = SEL_W'(fill_buf_ff);
      rdy_ext  = SEL_W'(ready_ff);
      if (rdy_ext > fill_ext) begin
         sel_wide = fill_ext + SEL_W'(NUM_BUFFERS) - rdy_ext;
      end else begin
         sel_wide = fill_ext - rdy_ext;
      end
      sel_buf = sel_wide[BUF_W-1:0];
      base_in = ADDR_W'(sel_buf * SAMPLES_PER_BUFFER);
   end

   assign burst_pos_in  = cmd.fetch_start ? '0 :
                          (cmd.fetch_issue ? burst_pos_ff + 1'b1 : burst_pos_ff);
   assign clear_addr_in = cmd.clear_wr ? clear_addr_ff + 1'b1 : clear_addr_ff;

   // memory ports
   assign fill_addr = ADDR_W'(fill_buf_ff * SAMPLES_PER_BUFFER) + ADDR_W'(fill_pos_ff);
   assign wr_addr   = cmd.clear_wr ? clear_addr_ff : fill_addr;
   assign wr_data   = cmd.clear_wr ? '0 : sample_in;
   assign mem_wr    = cmd.clear_wr || cmd.add;
   assign rd_addr   = base_ff + ADDR_W'(burst_pos_ff);

   always_ff @(posedge clock) begin
      if (mem_wr) mem[wr_addr] <= wr_data;
      if (cmd.fetch_issue) rd_data_ff <= mem[rd_addr];
   end

   // read pipe stage, status results ride along without a read
   assign pipe_vld_in = cmd.add || cmd.fetch_issue;
   assign rdy_pad     = {{READY_W{1'b0}}, ready_in};
   assign pipe_rdy_in = rdy_pad[READY_W-1:0];

   // two entry output queue
   assign push     = pipe_vld_ff;
   assign pop      = rsp_valid && !rsp_stall;
   assign room_sum = 3'(q_cnt_ff) + 3'(pipe_vld_ff) - 3'(pop);

   always_comb begin
      push_entry.sample = pipe_status_ff ? '0 : signed'(rd_data_ff);
      push_entry.last   = pipe_last_ff;
      push_entry.ready  = pipe_rdy_ff;
      q_wr_ptr_in = push ? ~q_wr_ptr_ff : q_wr_ptr_ff;
      q_rd_ptr_in = pop ? ~q_rd_ptr_ff : q_rd_ptr_ff;
      q_cnt_in    = q_cnt_ff + 2'(push) - 2'(pop);
   end

   assign rsp_valid       = (q_cnt_ff != 2'd0);
   assign rsp_sample_out  = q_ff[q_rd_ptr_ff].sample;
   assign rsp_last        = q_ff[q_rd_ptr_ff].last;
   assign rsp_ready_count = q_ff[q_rd_ptr_ff].ready;

   always_comb begin
      sts            = '0;
      sts.clear_done = (clear_addr_ff == ADDR_W'(DEPTH - 1));
      sts.credit_ok  = (room_sum < 3'd2);
      sts.burst_end  = (burst_pos_ff == POS_W'(SAMPLES_PER_BUFFER - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         fill_buf_ff   <= '0;
         fill_pos_ff   <= '0;
         ready_ff      <= '0;
         burst_pos_ff  <= '0;
         pipe_vld_ff   <= 1'b0;
         q_wr_ptr_ff   <= 1'b0;
         q_rd_ptr_ff   <= 1'b0;
         q_cnt_ff      <= 2'd0;
      end else begin
         clear_addr_ff <= clear_addr_in;
         fill_buf_ff   <= fill_buf_in;
         fill_pos_ff   <= fill_pos_in;
         ready_ff      <= ready_in;
         burst_pos_ff  <= burst_pos_in;
         pipe_vld_ff   <= pipe_vld_in;
         q_wr_ptr_ff   <= q_wr_ptr_in;
         q_rd_ptr_ff   <= q_rd_ptr_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_start) base_ff <= base_in;
      if (pipe_vld_in) begin
         pipe_status_ff <= cmd.add;
         pipe_last_ff   <= cmd.add || sts.burst_end;
         pipe_rdy_ff    <= pipe_rdy_in;
      end
      if (push) q_ff[q_wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== design/multi_buffer_sample_ring_core.sv =====
// ----------------------------------------------------------------------------
// multi_buffer_sample_ring_core
// ring of equal sample buffers with add and burst fetch
// ----------------------------------------------------------------------------
// The ring holds NUM_BUFFERS buffers of SAMPLES_PER_BUFFER signed 16-bit
// samples in one single-port-write, registered-read memory. After reset a
// clearing pass writes zero to every entry, one per cycle; req_stall is
// high during it. An add (req_func 0) returns one status transfer with
// sample 0 and last set. A fetch (req_func 1) first picks the oldest ready
// buffer, then makes one memory read per cycle while the output queue has
// room, the single read port setting the pace; its SAMPLES_PER_BUFFER
// transfers come out one per cycle when rsp_stall is low. A two-entry
// output queue lets new requests be taken while results wait; rsp_stall
// throttles the fetch reads. rsp_ready_count is the ready buffer count
// after the operation, kept to its low three bits.
// ----------------------------------------------------------------------------
`include "multi_buffer_sample_ring_core_defines.svh"

module multi_buffer_sample_ring_core import mbsr_pkg::*; #(
   parameter int NUM_BUFFERS        = 4,
   parameter int SAMPLES_PER_BUFFER = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_last,
   output logic [READY_W-1:0]         rsp_ready_count
);

   mbsr_cmd_type cmd;
   mbsr_sts_type sts;

   // sequencing: clear pass, request accept, burst read issue
   mbsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memory, ring pointers, read pipe and output queue
   mbsr_datapath #(
      .NUM_BUFFERS        (NUM_BUFFERS),
      .SAMPLES_PER_BUFFER (SAMPLES_PER_BUFFER)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .sample_in       (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last        (rsp_last),
      .rsp_ready_count (rsp_ready_count)
   );

   // no request transfer while the clearing pass still writes the memory
   `MBSR_ASSERT_NOW(a_no_req_in_clear, clock, reset, cmd.clear_wr, req_stall)

   // an add and a burst read never share the read pipe in one cycle
   `MBSR_ASSERT_NOW(a_pipe_exclusive, clock, reset, cmd.add, !cmd.fetch_issue)

   // after a fetch starts, requests are held off while its burst runs
   `MBSR_ASSERT_NEXT(a_fetch_holds_req, clock, reset, cmd.fetch_start, req_stall)

endmodule
